// ===== sv/vsp_pkg.sv =====
// Version string parser: shared types, constants and character-class helpers.
// No dependencies; every other file imports this package.
`default_nettype none
package vsp_pkg;

    // Longest text that can be valid; the character count saturates one above it
    localparam int unsigned MAX_TEXT_LENGTH = 64;
    localparam int unsigned CNT_W           = $clog2(MAX_TEXT_LENGTH + 2);
    localparam int unsigned TAG_W           = 6;
    localparam int unsigned NUM_W           = 32;
    localparam int unsigned NUM_COMPONENTS  = 3;

    localparam logic [CNT_W-1:0] COUNT_SAT   = CNT_W'(MAX_TEXT_LENGTH + 1);
    localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(MAX_TEXT_LENGTH);
    localparam logic [TAG_W-1:0] TAG_LEN_MAX = {TAG_W{1'b1}};

    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef enum logic [1:0] {
        PH_MAJOR = 2'd0,
        PH_MINOR = 2'd1,
        PH_PATCH = 2'd2,
        PH_TAG   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_LENGTH       = 3'd1,
        ERR_MISSING_DOT  = 3'd2,
        ERR_PRERELEASE   = 3'd3,
        ERR_EMPTY        = 3'd4,
        ERR_LEADING_ZERO = 3'd5,
        ERR_NOT_NUMBER   = 3'd6
    } err_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [NUM_W-1:0] value;
        logic [1:0]       digits;
        logic             first_zero;
        logic             bad;
    } comp_t;

    typedef struct packed {
        logic [CNT_W-1:0]               count;
        phase_t                         phase;
        comp_t [NUM_COMPONENTS-1:0]     comp;
        logic [TAG_W-1:0]               tag_len;
        logic                           tag_bad;
    } acc_t;

    typedef struct packed {
        logic             valid_res;
        err_t             error_code;
        logic [NUM_W-1:0] major_number;
        logic [NUM_W-1:0] minor_number;
        logic [NUM_W-1:0] patch_number;
        logic             has_prerelease;
        logic [TAG_W-1:0] prerelease_length;
    } res_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic tag_char_ok(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) ||
               ((c >= 8'h41) && (c <= 8'h5A)) ||
               is_digit(c) || (c == CH_DOT) || (c == CH_DASH);
    endfunction

endpackage
`default_nettype wire

// ===== sv/vsp_if.sv =====
// Version string parser: character and result channel interfaces.
// Depends on vsp_pkg.
`default_nettype none
interface vsp_char_if;
    import vsp_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       has_char;
    logic       last;

    modport source (output valid, output char_code, output has_char, output last,
                    input ready);
    modport sink   (input valid, input char_code, input has_char, input last,
                    output ready);
endinterface

interface vsp_result_if;
    import vsp_pkg::*;

    logic             valid;
    logic             ready;
    logic             valid_res;
    logic [2:0]       error_code;
    logic [NUM_W-1:0] major_number;
    logic [NUM_W-1:0] minor_number;
    logic [NUM_W-1:0] patch_number;
    logic             has_prerelease;
    logic [TAG_W-1:0] prerelease_length;

    modport source (output valid, output valid_res, output error_code,
                    output major_number, output minor_number, output patch_number,
                    output has_prerelease, output prerelease_length, input ready);
    modport sink   (input valid, input valid_res, input error_code,
                    input major_number, input minor_number, input patch_number,
                    input has_prerelease, input prerelease_length, output ready);
endinterface
`default_nettype wire

// ===== sv/vsp_accum.sv =====
// Version string parser: per-text accumulator (count, phase, components, tag).
// Depends on vsp_pkg.
`default_nettype none
module vsp_accum (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  vsp_pkg::item_t     item,
    input  wire logic          consume,
    output vsp_pkg::acc_t      upd
);
    import vsp_pkg::*;

    acc_t state_reg;
    acc_t state_next;
    logic [NUM_W+3:0] prod [NUM_COMPONENTS];

    // Fold one character into the state
    always_comb
    begin
        upd = state_reg;
        for (int k = 0; k < NUM_COMPONENTS; k++)
        begin
            prod[k] = ({4'b0, state_reg.comp[k].value} << 3) +
                      ({4'b0, state_reg.comp[k].value} << 1) +
                      (NUM_W+4)'(item.char_code[3:0]);
        end
        if (item.has_char)
        begin
            if (state_reg.count != COUNT_SAT)
                upd.count = state_reg.count + 1'b1;

            if (state_reg.phase == PH_TAG)
            begin
                if (state_reg.tag_len != TAG_LEN_MAX)
                    upd.tag_len = state_reg.tag_len + 1'b1;
                if (!tag_char_ok(item.char_code))
                    upd.tag_bad = 1'b1;
            end
            else if ((item.char_code == CH_DOT) && (state_reg.phase != PH_PATCH))
            begin
                upd.phase = phase_t'(state_reg.phase + 2'd1);
            end
            else if ((item.char_code == CH_DASH) && (state_reg.phase == PH_PATCH))
            begin
                upd.phase = PH_TAG;
            end
            else
            begin
                for (int k = 0; k < NUM_COMPONENTS; k++)
                begin
                    if (state_reg.phase == phase_t'(2'(k)))
                    begin
                        if ((state_reg.comp[k].digits == 2'd0) && (item.char_code == CH_ZERO))
                            upd.comp[k].first_zero = 1'b1;
                        if (state_reg.comp[k].digits != 2'd2)
                            upd.comp[k].digits = state_reg.comp[k].digits + 2'd1;
                        if (!is_digit(item.char_code))
                            upd.comp[k].bad = 1'b1;
                        else if (!state_reg.comp[k].bad)
                        begin
                            // stop accumulating at the first overflow
                            if (prod[k][NUM_W+3:NUM_W] != 4'd0)
                                upd.comp[k].bad = 1'b1;
                            else
                                upd.comp[k].value = prod[k][NUM_W-1:0];
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (consume)
            state_next = item.last ? '0 : upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else
            state_reg <= state_next;
    end

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.count <= COUNT_SAT)
        else $error("character count beyond saturation");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && item.last) |=> (state_reg.count == '0) && (state_reg.phase == PH_MAJOR)
                                    && (state_reg.tag_len == '0))
        else $error("state not cleared after final character");

    a_tag_only_in_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase != PH_TAG) |-> (state_reg.tag_len == '0) && !state_reg.tag_bad)
        else $error("tag state set outside prerelease phase");
endmodule
`default_nettype wire

// ===== sv/vsp_judge.sv =====
// Version string parser: error check and result formatting on the final character.
// Depends on vsp_pkg.
`default_nettype none
module vsp_judge (
    input  vsp_pkg::acc_t  acc,
    output vsp_pkg::res_t  res
);
    import vsp_pkg::*;

    err_t code;
    err_t comp_code;
    logic ok;

    // Components in order: empty, leading zero, not a number
    always_comb
    begin
        comp_code = ERR_NONE;
        for (int k = NUM_COMPONENTS - 1; k >= 0; k--)
        begin
            if (acc.comp[k].digits == 2'd0)
                comp_code = ERR_EMPTY;
            else if ((acc.comp[k].digits == 2'd2) && acc.comp[k].first_zero)
                comp_code = ERR_LEADING_ZERO;
            else if (acc.comp[k].bad)
                comp_code = ERR_NOT_NUMBER;
        end
    end

    always_comb
    begin
        if ((acc.count == '0) || (acc.count > COUNT_LIMIT))
            code = ERR_LENGTH;
        else if ((acc.phase == PH_MAJOR) || (acc.phase == PH_MINOR))
            code = ERR_MISSING_DOT;
        else if ((acc.phase == PH_TAG) && ((acc.tag_len == '0) || acc.tag_bad))
            code = ERR_PRERELEASE;
        else
            code = comp_code;
    end

    assign ok = (code == ERR_NONE);

    always_comb
    begin
        res.valid_res         = ok;
        res.error_code        = code;
        res.major_number      = ok ? acc.comp[0].value : '0;
        res.minor_number      = ok ? acc.comp[1].value : '0;
        res.patch_number      = ok ? acc.comp[2].value : '0;
        res.has_prerelease    = ok && (acc.phase == PH_TAG);
        res.prerelease_length = ok ? acc.tag_len : '0;
    end
endmodule
`default_nettype wire

// ===== sv/version_string_parser_core.sv =====
// Version string parser top level: input register, accumulator, judge, result register.
// Depends on vsp_pkg, vsp_if, vsp_accum and vsp_judge.
//
// Usage
//   chars  : one transfer per character of a version text (char_code, has_char,
//            last). has_char = 0 carries no character; with last = 0 it is a
//            bubble, with last = 1 it closes the text (an empty text if alone).
//   result : one transfer per text, produced by the transfer that carries last.
//            valid_res, error_code, the three numbers and the prerelease
//            presence and length; numbers and tag fields read zero on error.
// Timing
//   A character enters the input register on its transfer and is folded into the
//   running state when it leaves that register; when last, its result lands in the
//   result register at the same edge, and result.valid rises with it. One character
//   per cycle is sustained while no final character waits on a full result register;
//   the fold is one shift-add on the active component plus flag updates.
// Stalls
//   Characters keep flowing while a result waits. A final character waits in
//   the input register only while the result register is full and not being
//   taken, and chars.ready drops behind it.
// Reset
//   rst_n clears both registers' valid flags and the running state; the block
//   is ready for a new text as soon as reset is released.
`default_nettype none
module version_string_parser_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    vsp_char_if.sink          chars,
    vsp_result_if.source      result
);
    import vsp_pkg::*;

    logic  in_valid_reg;
    logic  in_valid_next;
    item_t in_item_reg;
    logic  res_valid_reg;
    logic  res_valid_next;
    res_t  res_reg;
    logic  consume;
    acc_t  upd;
    res_t  res_comb;

    // Advance the held character unless it is final and the result slot is blocked
    assign consume = in_valid_reg &&
                     (!in_item_reg.last || !res_valid_reg || result.ready);
    assign chars.ready = !in_valid_reg || consume;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (chars.valid && chars.ready)
            in_valid_next = 1'b1;
        else if (consume)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // Payload register: load on every transfer, no reset needed
    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            in_item_reg.char_code <= chars.char_code;
            in_item_reg.has_char  <= chars.has_char;
            in_item_reg.last      <= chars.last;
        end
    end

    vsp_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (in_item_reg),
        .consume (consume),
        .upd     (upd)
    );

    vsp_judge u_judge (
        .acc (upd),
        .res (res_comb)
    );

    // Result register: fill on a final character, drop on a transfer
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (consume && in_item_reg.last)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (consume && in_item_reg.last)
            res_reg <= res_comb;
    end

    assign result.valid             = res_valid_reg;
    assign result.valid_res         = res_reg.valid_res;
    assign result.error_code        = res_reg.error_code;
    assign result.major_number      = res_reg.major_number;
    assign result.minor_number      = res_reg.minor_number;
    assign result.patch_number      = res_reg.patch_number;
    assign result.has_prerelease    = res_reg.has_prerelease;
    assign result.prerelease_length = res_reg.prerelease_length;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !result.ready) |-> !(consume && in_item_reg.last))
        else $error("pending result overwritten");

    a_valid_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.valid_res == (res_reg.error_code == ERR_NONE)))
        else $error("valid_res disagrees with error code");

    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.valid_res) |->
            (res_reg.major_number == '0) && (res_reg.minor_number == '0) &&
            (res_reg.patch_number == '0) && !res_reg.has_prerelease &&
            (res_reg.prerelease_length == '0))
        else $error("numbers not cleared on error");

    a_char_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !consume) |=> in_valid_reg)
        else $error("held character lost");
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for version_string_parser_core: streams version texts one character per transfer,
// predicts each parse result and checks it field by field as it leaves the block.
// Depends on vsp_pkg, vsp_if and the parser RTL.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vsp_pkg::*;

    localparam int unsigned RANDOM_CHARS  = 500;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned PRESSURE_HOLD = 300;
    localparam int unsigned PRESSURE_TEXTS = 20;

    logic clk;
    logic rst_n;

    vsp_char_if   chars ();
    vsp_result_if result ();

    version_string_parser_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .result (result)
    );

    // Running parse state of the text in flight, mirrored from the character transfers
    int unsigned      seen_chars;
    phase_t           cur_phase;
    logic [NUM_W-1:0] comp_value      [NUM_COMPONENTS];
    int unsigned      comp_digits     [NUM_COMPONENTS];
    bit               comp_first_zero [NUM_COMPONENTS];
    bit               comp_bad        [NUM_COMPONENTS];
    logic [TAG_W-1:0] tag_count;
    bit               tag_has_bad;

    // Parse results still owed by the block, oldest first
    res_t        pending_versions [$];
    // Text being assembled before it is streamed
    logic [7:0]  draft [$];

    int unsigned mismatches      = 0;
    int unsigned cycle_count     = 0;
    int unsigned chars_sent      = 0;
    bit          no_idle         = 1'b0;
    int unsigned hold_off_cycles = 0;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic bit is_decimal(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Tag characters: letters, digits, dot and dash
    function automatic bit allowed_in_tag(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
               is_decimal(c) || (c == CH_DOT) || (c == CH_DASH);
    endfunction

    function automatic void clear_text();
        int unsigned k;
        seen_chars  = 0;
        cur_phase   = PH_MAJOR;
        tag_count   = '0;
        tag_has_bad = 1'b0;
        for (k = 0; k < NUM_COMPONENTS; k++)
        begin
            comp_value[k]      = '0;
            comp_digits[k]     = 0;
            comp_first_zero[k] = 1'b0;
            comp_bad[k]        = 1'b0;
        end
    endfunction

    // Fold one character into the running state
    function automatic void fold_char(input logic [7:0] c);
        int unsigned k;
        logic [63:0] wide;
        // the count saturates one above the longest legal text
        if (seen_chars <= MAX_TEXT_LENGTH)
            seen_chars++;
        if (cur_phase == PH_TAG)
        begin
            if (tag_count != TAG_LEN_MAX)
                tag_count++;
            if (!allowed_in_tag(c))
                tag_has_bad = 1'b1;
        end
        else if (c == CH_DOT && cur_phase != PH_PATCH)
        begin
            cur_phase = phase_t'(cur_phase + 1);
        end
        else if (c == CH_DASH && cur_phase == PH_PATCH)
        begin
            cur_phase = PH_TAG;
        end
        else
        begin
            // any other character lands in the active component, dots and dashes included
            k = cur_phase;
            if (comp_digits[k] == 0 && c == CH_ZERO)
                comp_first_zero[k] = 1'b1;
            if (comp_digits[k] < 2)
                comp_digits[k]++;
            if (!is_decimal(c))
            begin
                comp_bad[k] = 1'b1;
            end
            else if (!comp_bad[k])
            begin
                // stop accumulating at the first step past 32 bits
                wide = 64'(comp_value[k]) * 64'd10 + 64'(c - CH_ZERO);
                if (wide > 64'hFFFF_FFFF)
                    comp_bad[k] = 1'b1;
                else
                    comp_value[k] = wide[NUM_W-1:0];
            end
        end
    endfunction

    // Error in priority order: length, dots, tag, then each component in turn
    function automatic err_t grade_text();
        int unsigned k;
        if (seen_chars == 0 || seen_chars > MAX_TEXT_LENGTH)
            return ERR_LENGTH;
        if (cur_phase == PH_MAJOR || cur_phase == PH_MINOR)
            return ERR_MISSING_DOT;
        if (cur_phase == PH_TAG && (tag_count == 0 || tag_has_bad))
            return ERR_PRERELEASE;
        for (k = 0; k < NUM_COMPONENTS; k++)
        begin
            if (comp_digits[k] == 0)
                return ERR_EMPTY;
            if (comp_digits[k] >= 2 && comp_first_zero[k])
                return ERR_LEADING_ZERO;
            if (comp_bad[k])
                return ERR_NOT_NUMBER;
        end
        return ERR_NONE;
    endfunction

    // Close the text: queue its parse result and start afresh
    function automatic void close_text();
        res_t want;
        err_t code;
        code            = grade_text();
        want            = '0;
        want.error_code = code;
        if (code == ERR_NONE)
        begin
            want.valid_res         = 1'b1;
            want.major_number      = comp_value[0];
            want.minor_number      = comp_value[1];
            want.patch_number      = comp_value[2];
            want.has_prerelease    = (cur_phase == PH_TAG);
            want.prerelease_length = tag_count;
        end
        pending_versions = {pending_versions, want};
        clear_text();
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Sample at the edge: both sides only change after it, so the pre-edge values decide
    always @(posedge clk)
    begin : check_result
        res_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_versions.size() == 0)
            begin
                note_mismatch("result transfer with no text pending");
            end
            else
            begin
                want = pending_versions.pop_front();
                if (result.valid_res !== want.valid_res)
                    note_mismatch($sformatf("valid_res got %0b want %0b",
                                            result.valid_res, want.valid_res));
                if (result.error_code !== want.error_code)
                    note_mismatch($sformatf("error_code got %0d want %0d (%s)",
                                            result.error_code, want.error_code,
                                            want.error_code.name()));
                if (result.major_number !== want.major_number)
                    note_mismatch($sformatf("major_number got %0d want %0d",
                                            result.major_number, want.major_number));
                if (result.minor_number !== want.minor_number)
                    note_mismatch($sformatf("minor_number got %0d want %0d",
                                            result.minor_number, want.minor_number));
                if (result.patch_number !== want.patch_number)
                    note_mismatch($sformatf("patch_number got %0d want %0d",
                                            result.patch_number, want.patch_number));
                if (result.has_prerelease !== want.has_prerelease)
                    note_mismatch($sformatf("has_prerelease got %0b want %0b",
                                            result.has_prerelease, want.has_prerelease));
                if (result.prerelease_length !== want.prerelease_length)
                    note_mismatch($sformatf("prerelease_length got %0d want %0d",
                                            result.prerelease_length,
                                            want.prerelease_length));
            end
        end
    end

    // Hard stop if the block hangs or a result never arrives
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side pacing: mostly ready, short stalls, the odd long one,
    // and a long hold-off on request so the block backs up into its input
    // ------------------------------------------------------------------
    initial
    begin : result_pacer
        int unsigned run;
        result.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off_cycles != 0)
            begin
                result.ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            else if (no_idle || $urandom_range(0, 99) < 70)
            begin
                result.ready <= 1'b1;
                run = no_idle ? 1 : $urandom_range(1, 12);
                repeat (run) @(posedge clk);
            end
            else
            begin
                result.ready <= 1'b0;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
                repeat (run) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Character side
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one item, hold it until the transfer, predict, then maybe idle.
    // Valid is only dropped when a gap follows, so back-to-back items keep it high.
    task automatic send_item(input logic [7:0] c, input logic hc, input logic lst);
        int unsigned gap;
        chars.char_code <= c;
        chars.has_char  <= hc;
        chars.last      <= lst;
        chars.valid     <= 1'b1;
        @(posedge clk);
        while (!chars.ready)
            @(posedge clk);
        if (hc || lst)
            chars_sent++;
        if (hc)
            fold_char(c);
        if (lst)
            close_text();
        gap = pick_gap();
        if (gap > 0)
        begin
            chars.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stream the draft as one text, with optional bubbles between characters.
    // close_empty ends the text with a character-less last item instead.
    task automatic send_draft(input int unsigned bubble_pct, input bit close_empty);
        int unsigned n;
        int unsigned i;
        n = draft.size();
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < bubble_pct)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(draft[i], 1'b1, (i == n - 1) && !close_empty);
        end
        if (close_empty || n == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        draft.delete();
    endtask

    task automatic wait_drained();
        chars.valid <= 1'b0;
        while (pending_versions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Text building
    // ------------------------------------------------------------------
    function automatic void add_byte(input logic [7:0] c);
        draft = {draft, c};
    endfunction

    function automatic void append_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    // One numeric component: mostly clean numbers, some near the 32-bit edge,
    // leading zeros, empties and stray characters
    function automatic void add_component();
        int unsigned     r;
        longint unsigned near_top;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            append_str($sformatf("%0d", $urandom_range(0, 9)));
        end
        else if (r < 68)
        begin
            append_str($sformatf("%0d", $urandom_range(10, 99999)));
        end
        else if (r < 78)
        begin
            append_str($sformatf("%0d", $urandom()));
        end
        else if (r < 84)
        begin
            near_top = 64'd4294967290 + $urandom_range(0, 12);
            append_str($sformatf("%0d", near_top));
        end
        else if (r < 87)
        begin
            // a digit before a random 32-bit number: up to eleven digits, usually overflowing part way through
            append_str($sformatf("%0d%0d", $urandom_range(1, 9), $urandom()));
        end
        else if (r < 91)
        begin
            append_str($sformatf("0%0d", $urandom_range(0, 999)));
        end
        else if (r >= 95)
        begin
            append_str($sformatf("%0d", $urandom_range(0, 99)));
            add_byte(8'($urandom_range(0, 255)));
        end
        // otherwise leave the component empty
    endfunction

    function automatic void add_tag(input int unsigned len);
        int unsigned i;
        int unsigned r;
        for (i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                add_byte(8'($urandom_range("a", "z")));
            else if (r < 55)
                add_byte(8'($urandom_range("A", "Z")));
            else if (r < 80)
                add_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
            else if (r < 88)
                add_byte(CH_DOT);
            else if (r < 96)
                add_byte(CH_DASH);
            else
                add_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void build_version();
        add_component();
        add_byte(CH_DOT);
        add_component();
        add_byte(CH_DOT);
        add_component();
        if ($urandom_range(0, 2) == 0)
        begin
            add_byte(CH_DASH);
            add_tag($urandom_range(0, 8));
        end
    endfunction

    // Break a well-formed text: drop, overwrite or insert a separator
    function automatic void mutate_draft();
        int unsigned pos;
        if (draft.size() == 0)
            return;
        pos = $urandom_range(0, draft.size() - 1);
        case ($urandom_range(0, 3))
            0:       draft.delete(pos);
            1:       draft[pos] = 8'($urandom_range(0, 255));
            2:       draft.insert(pos, CH_DOT);
            default: draft.insert(pos, CH_DASH);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes of each field and every error, in priority order
    task automatic test_directed();
        string cases [0:18];
        int unsigned i;
        int unsigned tag_len [0:2];
        cases = '{
            "0.0.0",
            "4294967295.4294967295.4294967295",
            "4294967296.0.1",
            "1.2",
            "1.2.3-",
            "10.20.30-rc.1-Zz9",
            "1.2.3-a_b",
            ".1.2",
            "01.2.3",
            "0x.1.2",
            "1a.2.3",
            "1.2.3.4",
            "1-2.3.4",
            "1.0.07",
            "1..3",
            "9:.1.1",
            "1/.1.1",
            "1.1.1-azAZ09",
            "1.1.1-@[`{"
        };
        // texts of exactly the limit, one over, and far over (tag length saturates)
        tag_len = '{58, 59, 74};

        for (i = 0; i < 19; i++)
        begin
            append_str(cases[i]);
            send_draft(0, 1'b0);
        end

        // empty text: a lone closing item with no character
        send_item(8'hFF, 1'b0, 1'b1);

        // a bubble that ends nothing, then a text with bubbles and a character-less close
        send_item(8'h00, 1'b0, 1'b0);
        append_str("7.8.9-x");
        send_draft(50, 1'b1);

        // tag holding the byte extremes
        append_str("1.2.3-");
        add_byte(8'h00);
        add_byte(8'hFF);
        send_draft(0, 1'b0);

        for (i = 0; i < 3; i++)
        begin
            append_str("1.2.3-");
            repeat (tag_len[i]) add_byte("a");
            send_draft(0, 1'b0);
        end
    endtask

    // Hold the result side off while characters keep coming: the result register
    // fills, a final character parks in the input register and chars.ready drops.
    // Once released, run with no idling on either side.
    task automatic test_back_pressure();
        int unsigned i;
        no_idle         = 1'b1;
        hold_off_cycles = PRESSURE_HOLD;
        for (i = 0; i < PRESSURE_TEXTS; i++)
        begin
            build_version();
            send_draft(0, 1'b0);
        end
        no_idle = 1'b0;
    endtask

    // Mostly well-formed texts with random content, mixed with broken ones, noise,
    // texts around the length limit and empty texts
    task automatic test_random();
        int unsigned goal;
        int unsigned r;
        goal = chars_sent + RANDOM_CHARS;
        while (chars_sent < goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                build_version();
            end
            else if (r < 82)
            begin
                build_version();
                mutate_draft();
            end
            else if (r < 92)
            begin
                repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
            end
            else if (r < 97)
            begin
                append_str($sformatf("%0d.%0d.%0d-", $urandom_range(0, 9),
                                     $urandom_range(0, 9), $urandom_range(0, 9)));
                add_tag($urandom_range(50, 70));
            end
            // otherwise an empty text
            send_draft(($urandom_range(0, 3) == 0) ? 15 : 0, $urandom_range(0, 9) == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           <= 1'b0;
        chars.valid     <= 1'b0;
        chars.char_code <= '0;
        chars.has_char  <= 1'b0;
        chars.last      <= 1'b0;
        clear_text();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        wait_drained();
        test_back_pressure();
        wait_drained();
        test_random();
        wait_drained();

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire

// ===== version_string_parser_core.f =====
sv/vsp_pkg.sv
sv/vsp_if.sv
sv/vsp_accum.sv
sv/vsp_judge.sv
sv/version_string_parser_core.sv
tb/tb_top.sv
